>>> rtl/core/gsa_pkg.sv
// Package for the generational slot allocator.
// Holds table sizes, request and status codes, and the controller/datapath structs.
// No dependencies.
package gsa_pkg;

  localparam int unsigned SLOTS = 256;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned GEN_W = 32;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_CHECK   = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  typedef struct packed {
    logic latch;
    logic pop;
    logic fetch_top_gen;
    logic fetch_req_gen;
    logic grant_new;
    logic grant_full;
    logic bump;
    logic resolve;
    logic reject;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       stack_empty;
    logic       table_full;
  } stat_t;

endpackage

>>> rtl/core/generational_slot_allocator.sv
// Steps after accept: a fresh-slot or full allocate and an unused kind finish in DECODE,
// release and check go on through CHECK, an allocate from the free stack through POP and BUMP.
// No new transaction is taken while busy; the next start is taken in the cycle the
// result is shown. The stack read and the generation memory read run in series.
// Reset: asynchronous, active low; clears alive bits, stack depth and used count.
// The receiver cannot stall: done_o is high for exactly one cycle; the result ports hold until the next result.
module generational_slot_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  kind_i,
  input  logic [gsa_pkg::IDX_W-1:0]   slot_index_i,
  input  logic [gsa_pkg::GEN_W-1:0]   handle_generation_i,
  output logic                        done_o,
  output logic [gsa_pkg::IDX_W-1:0]   out_index_o,
  output logic [gsa_pkg::GEN_W-1:0]   out_generation_o,
  output logic [1:0]                  status_o
);
  import gsa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  gsa_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .kind_i              (kind_i),
    .slot_index_i        (slot_index_i),
    .handle_generation_i (handle_generation_i),
    .done_o              (done_o),
    .out_index_o         (out_index_o),
    .out_generation_o    (out_generation_o),
    .status_o            (status_o)
  );

endmodule

>>> rtl/core/gsa_ctrl.sv
// Controller of the generational slot allocator: sequences one transaction.
// Depends on gsa_pkg.
module gsa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  gsa_pkg::stat_t stat_i,
  output gsa_pkg::cmd_t  cmd_o
);
  import gsa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP,
    ST_BUMP,
    ST_CHECK
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        unique case (stat_i.kind)
          KIND_ALLOC: begin
            if (!stat_i.stack_empty) begin
              cmd_o.pop = 1'b1;
              state_d   = ST_POP;
            end else if (!stat_i.table_full) begin
              cmd_o.grant_new = 1'b1;
            end else begin
              cmd_o.grant_full = 1'b1;
            end
          end
          KIND_RELEASE, KIND_CHECK: begin
            cmd_o.fetch_req_gen = 1'b1;
            state_d             = ST_CHECK;
          end
          default: cmd_o.reject = 1'b1;
        endcase
      end
      ST_POP: begin
        cmd_o.fetch_top_gen = 1'b1;
        state_d             = ST_BUMP;
      end
      ST_BUMP: begin
        cmd_o.bump = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_CHECK: begin
        cmd_o.resolve = 1'b1;
        state_d       = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy = busy_q;

endmodule

>>> rtl/core/gsa_datapath.sv
// Datapath of the generational slot allocator: generation and free-stack memories,
// alive bits, counters and the result register. Depends on gsa_pkg.
module gsa_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gsa_pkg::cmd_t               cmd_i,
  output gsa_pkg::stat_t              stat_o,
  input  logic [1:0]                  kind_i,
  input  logic [gsa_pkg::IDX_W-1:0]   slot_index_i,
  input  logic [gsa_pkg::GEN_W-1:0]   handle_generation_i,
  output logic                        done_o,
  output logic [gsa_pkg::IDX_W-1:0]   out_index_o,
  output logic [gsa_pkg::GEN_W-1:0]   out_generation_o,
  output logic [1:0]                  status_o
);
  import gsa_pkg::*;

  logic [1:0]       kind_q;
  logic [IDX_W-1:0] req_idx_q;
  logic [GEN_W-1:0] req_gen_q;

  logic [GEN_W-1:0] gen_mem [SLOTS];
  logic [IDX_W-1:0] stack_mem [SLOTS];
  logic [GEN_W-1:0] gen_rdata_q;
  logic             alive_rd_q;
  logic [IDX_W-1:0] top_q;
  logic [SLOTS-1:0] alive_q;
  logic [CNT_W-1:0] depth_q;
  logic [CNT_W-1:0] used_q;

  logic             done_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [GEN_W-1:0] out_gen_q;
  logic [1:0]       status_q;

  logic [CNT_W-1:0] depth_dec;
  logic [GEN_W-1:0] gen_inc;
  logic             handle_ok;
  logic             do_free;
  logic             gen_we;
  logic [IDX_W-1:0] gen_waddr;
  logic [GEN_W-1:0] gen_wdata;
  logic [IDX_W-1:0] gen_raddr;

  assign depth_dec = depth_q - CNT_W'(1);
  assign gen_inc   = gen_rdata_q + GEN_W'(1);
  assign handle_ok = ({1'b0, req_idx_q} < used_q) && alive_rd_q
                     && (gen_rdata_q == req_gen_q);
  assign do_free   = cmd_i.resolve && (kind_q == KIND_RELEASE) && handle_ok;

  assign gen_we    = cmd_i.grant_new || cmd_i.bump;
  assign gen_waddr = cmd_i.grant_new ? used_q[IDX_W-1:0] : top_q;
  assign gen_wdata = cmd_i.grant_new ? '0 : gen_inc;
  assign gen_raddr = cmd_i.fetch_top_gen ? top_q : req_idx_q;

  assign stat_o.kind        = kind_q;
  assign stat_o.stack_empty = (depth_q == '0);
  assign stat_o.table_full  = (used_q == CNT_W'(SLOTS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q    <= kind_i;
      req_idx_q <= slot_index_i;
      req_gen_q <= handle_generation_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (cmd_i.fetch_top_gen || cmd_i.fetch_req_gen) begin
      gen_rdata_q <= gen_mem[gen_raddr];
    end
    if (cmd_i.fetch_req_gen) begin
      alive_rd_q <= alive_q[req_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_free && (depth_q < CNT_W'(SLOTS))) begin
      stack_mem[depth_q[IDX_W-1:0]] <= req_idx_q;
    end
    if (cmd_i.pop) begin
      top_q <= stack_mem[depth_dec[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= '0;
      depth_q <= '0;
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.grant_new || cmd_i.grant_full || cmd_i.bump
                || cmd_i.resolve || cmd_i.reject;
      if (cmd_i.pop) begin
        depth_q <= depth_dec;
      end else if (do_free && (depth_q < CNT_W'(SLOTS))) begin
        depth_q <= depth_q + CNT_W'(1);
      end
      if (cmd_i.grant_new) begin
        used_q                          <= used_q + CNT_W'(1);
        alive_q[used_q[IDX_W-1:0]]      <= 1'b1;
      end
      if (cmd_i.bump) begin
        alive_q[top_q] <= 1'b1;
      end
      if (do_free) begin
        alive_q[req_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grant_new) begin
      out_idx_q <= used_q[IDX_W-1:0];
      out_gen_q <= '0;
      status_q  <= STATUS_OK;
    end else if (cmd_i.grant_full) begin
      out_idx_q <= '0;
      out_gen_q <= '0;
      status_q  <= STATUS_FULL;
    end else if (cmd_i.bump) begin
      out_idx_q <= top_q;
      out_gen_q <= gen_inc;
      status_q  <= STATUS_OK;
    end else if (cmd_i.resolve) begin
      out_idx_q <= req_idx_q;
      out_gen_q <= req_gen_q;
      status_q  <= handle_ok ? STATUS_OK : STATUS_INVALID;
    end else if (cmd_i.reject) begin
      out_idx_q <= req_idx_q;
      out_gen_q <= req_gen_q;
      status_q  <= STATUS_INVALID;
    end
  end

  assign done_o           = done_q;
  assign out_index_o      = out_idx_q;
  assign out_generation_o = out_gen_q;
  assign status_o         = status_q;

endmodule

>>> rtl/core/gsa_checker.sv
// Port checker for the generational slot allocator, bound to the top level.
// Depends on gsa_pkg.
module gsa_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      done_o,
  input logic [gsa_pkg::IDX_W-1:0] out_index_o,
  input logic [gsa_pkg::GEN_W-1:0] out_generation_o,
  input logic [1:0]                status_o
);
  import gsa_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == STATUS_OK || status_o == STATUS_INVALID
                || status_o == STATUS_FULL))
    else $error("undefined status code");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == STATUS_FULL |-> out_index_o == '0 && out_generation_o == '0)
    else $error("full result carries non-zero handle");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .out_index_o      (out_index_o),
  .out_generation_o (out_generation_o),
  .status_o         (status_o)
);
